[src/rain_sensing_wiper_controller_top_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the rain sensing wiper controller checker
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RAIN_SENSING_WIPER_CONTROLLER_TOP_ASSERT_SVH
`define RAIN_SENSING_WIPER_CONTROLLER_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define RSWC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define RSWC_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

[src/rswc_pkg.sv]
// ----------------------------------------------------------------------------
// rswc_pkg
// Types, register indexes, reset values and display tables of the wiper
// controller.
// ----------------------------------------------------------------------------
package rswc_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_SAMPLE_INTERVAL = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LIGHT_SWEEP     = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_MEDIUM_SWEEP    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_HEAVY_SWEEP     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BURST_PERIODS   = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_SAMPLE_INTERVAL = 8'd10;
  localparam logic [7:0] RST_LIGHT_SWEEP     = 8'd160;
  localparam logic [7:0] RST_MEDIUM_SWEEP    = 8'd100;
  localparam logic [7:0] RST_HEAVY_SWEEP     = 8'd60;
  localparam logic [6:0] RST_BURST_PERIODS   = 7'd100;

  // PWM slot positions
  localparam logic [2:0] PWM_LAST_SLOT = 3'd4;
  localparam logic [2:0] PWM_PARKED    = 3'd5;

  // Input action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SLOT = 1'b1;

  // Segment code of digit zero
  localparam logic [6:0] SEG_ZERO = 7'h3f;

  typedef struct packed {
    logic       motor_a;
    logic       motor_b;
    logic [2:0] led_pattern;
    logic [6:0] seg_hundreds;
    logic [6:0] seg_tens;
    logic [6:0] seg_ones;
    logic [1:0] rain_level;
  } res_t;

  function automatic logic [6:0] seg_code(input logic [3:0] digit);
    logic [6:0] code;
    case (digit)
      4'd0: code = 7'h3f;
      4'd1: code = 7'h06;
      4'd2: code = 7'h5b;
      4'd3: code = 7'h4f;
      4'd4: code = 7'h66;
      4'd5: code = 7'h6d;
      4'd6: code = 7'h7d;
      4'd7: code = 7'h07;
      4'd8: code = 7'h7f;
      4'd9: code = 7'h6f;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

  // Active-low LED pattern, one lit LED per nonzero level, none at level zero
  function automatic logic [2:0] led_code(input logic [1:0] lvl);
    logic [2:0] leds;
    case (lvl)
      2'd0: leds = 3'd7;
      2'd1: leds = 3'd6;
      2'd2: leds = 3'd5;
      2'd3: leds = 3'd3;
      default: leds = 3'd7;
    endcase
    return leds;
  endfunction

endpackage

[src/rain_sensing_wiper_controller_top.sv]
// ----------------------------------------------------------------------------
// rain_sensing_wiper_controller_top
// Rain level sampling, sweep timing and burst PWM drive for a wiper motor,
// with active-low level LEDs and seven-segment codes of the latched sample.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  in      | in_valid / in_stall   | in_action, in_rain_sample
//  out     | out_valid / out_stall | out_motor_a, out_motor_b, out_led_pattern,
//          |                       | out_seg_hundreds/tens/ones, out_rain_level
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One word in, one word out; a word can be taken every cycle while in_stall is low.
//  State update and result form in one pass of logic off the state registers.
//  A skid register behind the result register takes one more word under
//  output stall; in_stall rises once the skid is full and drops when it drains.
//  Reset (rst_n low, synchronous) restores register defaults, clears all state
//  and empties the output. cfg_ready is always high.
//
module rain_sensing_wiper_controller_top (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_action,
  input  logic [7:0]                      in_rain_sample,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_motor_a,
  output logic                            out_motor_b,
  output logic [2:0]                      out_led_pattern,
  output logic [6:0]                      out_seg_hundreds,
  output logic [6:0]                      out_seg_tens,
  output logic [6:0]                      out_seg_ones,
  output logic [1:0]                      out_rain_level,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rswc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [rswc_pkg::CfgDataW-1:0]   cfg_data
);
  import rswc_pkg::*;

  // Configuration registers
  logic [7:0] sample_interval_r;
  logic [7:0] light_sweep_r;
  logic [7:0] medium_sweep_r;
  logic [7:0] heavy_sweep_r;
  logic [6:0] burst_periods_r;

  // Controller state
  logic [7:0] tick_count_r,  tick_count_nxt;
  logic [1:0] level_r,       level_nxt;
  logic [7:0] sweep_count_r, sweep_count_nxt;
  logic       direction_r,   direction_nxt;
  logic [6:0] burst_count_r, burst_count_nxt;
  logic [2:0] pwm_slot_r,    pwm_slot_nxt;
  logic [6:0] seg_h_r,       seg_h_nxt;
  logic [6:0] seg_t_r,       seg_t_nxt;
  logic [6:0] seg_o_r,       seg_o_nxt;

  // Output register and skid register
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t out_data_r, out_data_nxt;
  res_t skid_data_r, skid_data_nxt;

  logic in_acc;
  logic out_take;
  logic cfg_wr;

  // Digit split of the incoming sample
  logic [1:0]  hund_digit;
  logic [7:0]  rem_full;
  logic [6:0]  rem;
  logic [14:0] tens_prod;
  logic [3:0]  tens_digit;
  logic [6:0]  ones_full;

  logic [7:0] limit;
  logic       drive;
  res_t       res;

  assign in_stall  = skid_valid_r;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid & ~in_stall;
  assign out_take  = out_valid_r & ~out_stall;
  assign cfg_wr    = cfg_valid & cfg_ready;

  // Split the sample into decimal digits: compare for hundreds, reciprocal
  // multiply (x205 >> 11, exact below 100) for tens, subtract for ones.
  always_comb begin
    if (in_rain_sample >= 8'd200) begin
      hund_digit = 2'd2;
      rem_full   = in_rain_sample - 8'd200;
    end else if (in_rain_sample >= 8'd100) begin
      hund_digit = 2'd1;
      rem_full   = in_rain_sample - 8'd100;
    end else begin
      hund_digit = 2'd0;
      rem_full   = in_rain_sample;
    end
    rem        = rem_full[6:0];
    tens_prod  = {8'b0, rem} * 15'd205;
    tens_digit = tens_prod[14:11];
    ones_full  = rem - ({3'b0, tens_digit} * 7'd10);
  end

  // Next state for one accepted word
  always_comb begin
    tick_count_nxt  = tick_count_r;
    level_nxt       = level_r;
    sweep_count_nxt = sweep_count_r;
    direction_nxt   = direction_r;
    burst_count_nxt = burst_count_r;
    pwm_slot_nxt    = pwm_slot_r;
    seg_h_nxt       = seg_h_r;
    seg_t_nxt       = seg_t_r;
    seg_o_nxt       = seg_o_r;
    limit           = heavy_sweep_r;

    if (in_action == ACT_TICK) begin
      // count to the sample interval, latch on rollover
      if (tick_count_r < sample_interval_r) begin
        tick_count_nxt = tick_count_r + 8'd1;
      end else begin
        tick_count_nxt = 8'd0;
        level_nxt      = in_rain_sample[7:6];
        seg_h_nxt      = seg_code({2'b0, hund_digit});
        seg_t_nxt      = seg_code(tens_digit);
        seg_o_nxt      = seg_code(ones_full[3:0]);
      end
      case (level_nxt)
        2'd1:    limit = light_sweep_r;
        2'd2:    limit = medium_sweep_r;
        default: limit = heavy_sweep_r;
      endcase
      // sweep runs only while it rains; rollover reverses and restarts burst
      if (level_nxt != 2'd0) begin
        if (sweep_count_r < limit) begin
          sweep_count_nxt = sweep_count_r + 8'd1;
        end else begin
          sweep_count_nxt = 8'd0;
          direction_nxt   = ~direction_r;
          burst_count_nxt = 7'd0;
        end
      end
    end else begin
      // advance the PWM slot; park once the burst is spent
      if (burst_count_r < burst_periods_r) begin
        if (pwm_slot_r < PWM_LAST_SLOT) begin
          pwm_slot_nxt = pwm_slot_r + 3'd1;
        end else begin
          pwm_slot_nxt    = 3'd0;
          burst_count_nxt = burst_count_r + 7'd1;
        end
      end else begin
        pwm_slot_nxt = PWM_PARKED;
      end
    end
  end

  // Result from the updated state
  always_comb begin
    drive            = pwm_slot_nxt < {1'b0, level_nxt};
    res.motor_a      = drive ? direction_nxt : 1'b1;
    res.motor_b      = drive ? ~direction_nxt : 1'b1;
    res.led_pattern  = led_code(level_nxt);
    res.seg_hundreds = seg_h_nxt;
    res.seg_tens     = seg_t_nxt;
    res.seg_ones     = seg_o_nxt;
    res.rain_level   = level_nxt;
  end

  // Output register and skid steering
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      // drain the skid into the output register
      if (out_take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = res;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_interval_r <= RST_SAMPLE_INTERVAL;
      light_sweep_r     <= RST_LIGHT_SWEEP;
      medium_sweep_r    <= RST_MEDIUM_SWEEP;
      heavy_sweep_r     <= RST_HEAVY_SWEEP;
      burst_periods_r   <= RST_BURST_PERIODS;
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_SAMPLE_INTERVAL: sample_interval_r <= cfg_data;
        REG_LIGHT_SWEEP:     light_sweep_r     <= cfg_data;
        REG_MEDIUM_SWEEP:    medium_sweep_r    <= cfg_data;
        REG_HEAVY_SWEEP:     heavy_sweep_r     <= cfg_data;
        REG_BURST_PERIODS:   burst_periods_r   <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Controller state, advanced once per accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_count_r  <= 8'd0;
      level_r       <= 2'd0;
      sweep_count_r <= 8'd0;
      direction_r   <= 1'b0;
      burst_count_r <= 7'd0;
      pwm_slot_r    <= 3'd0;
      seg_h_r       <= SEG_ZERO;
      seg_t_r       <= SEG_ZERO;
      seg_o_r       <= SEG_ZERO;
    end else if (in_acc) begin
      tick_count_r  <= tick_count_nxt;
      level_r       <= level_nxt;
      sweep_count_r <= sweep_count_nxt;
      direction_r   <= direction_nxt;
      burst_count_r <= burst_count_nxt;
      pwm_slot_r    <= pwm_slot_nxt;
      seg_h_r       <= seg_h_nxt;
      seg_t_r       <= seg_t_nxt;
      seg_o_r       <= seg_o_nxt;
    end
  end

  // Output handshake flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_motor_a      = out_data_r.motor_a;
  assign out_motor_b      = out_data_r.motor_b;
  assign out_led_pattern  = out_data_r.led_pattern;
  assign out_seg_hundreds = out_data_r.seg_hundreds;
  assign out_seg_tens     = out_data_r.seg_tens;
  assign out_seg_ones     = out_data_r.seg_ones;
  assign out_rain_level   = out_data_r.rain_level;

endmodule

[src/rswc_checker.sv]
// ----------------------------------------------------------------------------
// rswc_checker
// Port-level checks of the wiper controller, bound to its top level.
// ----------------------------------------------------------------------------
`include "rain_sensing_wiper_controller_top_assert.svh"

module rswc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_motor_a,
  input logic       out_motor_b,
  input logic [2:0] out_led_pattern,
  input logic [1:0] out_rain_level
);

  logic       dry_ok;
  logic [2:0] led_want;

  // motor stopped whenever the level is zero
  assign dry_ok = (out_rain_level != 2'd0) || (out_motor_a && out_motor_b);

  // active-low LED pattern expected for the level
  always_comb begin
    case (out_rain_level)
      2'd0:    led_want = 3'd7;
      2'd1:    led_want = 3'd6;
      2'd2:    led_want = 3'd5;
      2'd3:    led_want = 3'd3;
      default: led_want = 3'd7;
    endcase
  end

  // hold a stalled result
  `RSWC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")

  // never drive both motor lines low
  `RSWC_ASSERT(a_motor_legal, !out_valid || out_motor_a || out_motor_b, "both motor lines low")

  // no drive without rain
  `RSWC_ASSERT(a_dry_stop, !out_valid || dry_ok, "motor driven at level zero")

  // LEDs track the level
  `RSWC_ASSERT(a_led_level, !out_valid || out_led_pattern == led_want, "LED pattern off level")

endmodule

bind rain_sensing_wiper_controller_top rswc_checker u_rswc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_motor_a     (out_motor_a),
  .out_motor_b     (out_motor_b),
  .out_led_pattern (out_led_pattern),
  .out_rain_level  (out_rain_level)
);

[test/tb_rain_sensing_wiper_controller_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rain_sensing_wiper_controller_top
// Self-checking bench for the wiper controller. Words go in as timer ticks and
// PWM slot steps. A cycle model of the sampler, sweep timer and burst PWM
// predicts each result word that has no hand-written one, and the bench compares each word field by field.
// Random input gaps, random output stalls and one long output hold-off stress the
// handshakes. The register settings change between phases.
// ----------------------------------------------------------------------------
module tb_rain_sensing_wiper_controller_top;
  import rswc_pkg::*;

  localparam int unsigned PHASES         = 6;
  localparam int unsigned PHASE_WORDS    = 170;
  localparam int unsigned LONG_HOLD      = 200;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // Seven-segment glyphs for digits 0..9
  localparam logic [6:0] GLYPH [10] = '{
    7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
  };

  // One directed word. Rows with fixed set carry a hand-written result.
  typedef struct packed {
    logic       act;
    logic [7:0] smp;
    logic       fixed;
    res_t       want;
  } stim_row_t;

  localparam res_t PARKED_BLANK = '{1'b1, 1'b1, 3'd7, SEG_ZERO, SEG_ZERO, SEG_ZERO, 2'd0};

  localparam stim_row_t DIR_ROWS [24] = '{
    // first slot step after reset: motor off, level 0, display reads 000
    '{ACT_SLOT, 8'h00, 1'b1, PARKED_BLANK},
    // full-scale sample latches at once (interval 0): level 3, drive direction 0, "255"
    '{ACT_TICK, 8'hff, 1'b1, '{1'b0, 1'b1, 3'd3, 7'h5b, 7'h6d, 7'h6d, 2'd3}},
    // zero sample drops back to level 0
    '{ACT_TICK, 8'h00, 1'b1, PARKED_BLANK},
    '{ACT_TICK, 8'h3f, 1'b0, '0},
    '{ACT_TICK, 8'h40, 1'b0, '0},
    '{ACT_SLOT, 8'h5a, 1'b0, '0},
    '{ACT_TICK, 8'h80, 1'b0, '0},
    '{ACT_TICK, 8'hbf, 1'b0, '0},
    '{ACT_TICK, 8'hc0, 1'b0, '0},
    '{ACT_SLOT, 8'ha5, 1'b0, '0},
    '{ACT_SLOT, 8'hff, 1'b0, '0},
    '{ACT_SLOT, 8'h00, 1'b0, '0},
    '{ACT_SLOT, 8'h3c, 1'b0, '0},
    '{ACT_TICK, 8'h7f, 1'b0, '0},
    '{ACT_TICK, 8'hc7, 1'b0, '0},
    '{ACT_TICK, 8'h64, 1'b0, '0},
    '{ACT_TICK, 8'h09, 1'b0, '0},
    '{ACT_TICK, 8'haa, 1'b0, '0},
    '{ACT_TICK, 8'h55, 1'b0, '0},
    '{ACT_SLOT, 8'h00, 1'b0, '0},
    '{ACT_SLOT, 8'h00, 1'b0, '0},
    '{ACT_SLOT, 8'h00, 1'b0, '0},
    '{ACT_SLOT, 8'h00, 1'b0, '0},
    '{ACT_SLOT, 8'h00, 1'b0, '0}
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_action;
  logic [7:0]          in_rain_sample;
  logic                out_valid;
  logic                out_stall;
  logic                out_motor_a;
  logic                out_motor_b;
  logic [2:0]          out_led_pattern;
  logic [6:0]          out_seg_hundreds;
  logic [6:0]          out_seg_tens;
  logic [6:0]          out_seg_ones;
  logic [1:0]          out_rain_level;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  // Hand-written result that travels with the word on the input port
  logic                row_fixed;
  res_t                row_want;

  // Stall control shared by the sender and the output stall process
  logic                quiet;
  logic                hold_req;
  logic                holding;

  int                  fail_count  = 0;
  int                  idle_cycles = 0;
  res_t                drive_words_q [$];

  // Predicted register file
  logic [7:0]          c_interval;
  logic [7:0]          c_light;
  logic [7:0]          c_medium;
  logic [7:0]          c_heavy;
  logic [6:0]          c_burst;

  // Predicted controller state
  logic [7:0]          m_tick;
  logic [7:0]          m_rain;
  logic [1:0]          m_level;
  logic [7:0]          m_sweep;
  logic                m_dir;
  logic [6:0]          m_burst;
  logic [2:0]          m_slot;

  rain_sensing_wiper_controller_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_rain_sample   (in_rain_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_motor_a      (out_motor_a),
    .out_motor_b      (out_motor_b),
    .out_led_pattern  (out_led_pattern),
    .out_seg_hundreds (out_seg_hundreds),
    .out_seg_tens     (out_seg_tens),
    .out_seg_ones     (out_seg_ones),
    .out_rain_level   (out_rain_level),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Advance the predicted state by one word and return the result word it gives.
  function automatic res_t wiper_step(input logic act, input logic [7:0] smp);
    logic [7:0] limit;
    res_t       r;
    if (act == ACT_TICK) begin
      // Count up to the interval, then latch the sample and its level
      if (m_tick < c_interval) begin
        m_tick = m_tick + 8'd1;
      end else begin
        m_tick  = '0;
        m_rain  = smp;
        m_level = smp[7:6];
      end
      // Run the sweep timer only while it rains. A rollover flips the
      // direction and starts a fresh burst.
      if (m_level != 2'd0) begin
        case (m_level)
          2'd1:    limit = c_light;
          2'd2:    limit = c_medium;
          default: limit = c_heavy;
        endcase
        if (m_sweep < limit) begin
          m_sweep = m_sweep + 8'd1;
        end else begin
          m_sweep = '0;
          m_dir   = ~m_dir;
          m_burst = '0;
        end
      end
    end else begin
      // Step the PWM slot while burst periods remain, else park it
      if (m_burst < c_burst) begin
        if (m_slot < PWM_LAST_SLOT) begin
          m_slot = m_slot + 3'd1;
        end else begin
          m_slot  = '0;
          m_burst = m_burst + 7'd1;
        end
      end else begin
        m_slot = PWM_PARKED;
      end
    end
    // Drive only in the first level-many slots. Both lines high means stopped.
    r.motor_a = 1'b1;
    r.motor_b = 1'b1;
    if (m_slot < m_level) begin
      if (m_dir) r.motor_b = 1'b0;
      else       r.motor_a = 1'b0;
    end
    r.led_pattern  = (m_level == 2'd0) ? 3'b111 : 3'b111 ^ (3'b001 << (m_level - 2'd1));
    r.seg_hundreds = GLYPH[m_rain / 100];
    r.seg_tens     = GLYPH[(m_rain % 100) / 10];
    r.seg_ones     = GLYPH[m_rain % 10];
    r.rain_level   = m_level;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // Monitor: sample every handshake on the rising edge. Check results first,
  // then track register writes, then predict the word taken on the input.
  always @(posedge clk) begin : monitor
    res_t want;
    res_t predicted;
    logic moved;
    moved = 1'b0;
    if (!rst_n) begin
      c_interval = RST_SAMPLE_INTERVAL;
      c_light    = RST_LIGHT_SWEEP;
      c_medium   = RST_MEDIUM_SWEEP;
      c_heavy    = RST_HEAVY_SWEEP;
      c_burst    = RST_BURST_PERIODS;
      m_tick     = '0;
      m_rain     = '0;
      m_level    = '0;
      m_sweep    = '0;
      m_dir      = 1'b0;
      m_burst    = '0;
      m_slot     = '0;
      drive_words_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (drive_words_q.size() == 0) begin
          $error("result word arrived with nothing expected");
          fail_count++;
        end else begin
          want = drive_words_q.pop_front();
          check_field("motor_a",      want.motor_a,      out_motor_a);
          check_field("motor_b",      want.motor_b,      out_motor_b);
          check_field("led_pattern",  want.led_pattern,  out_led_pattern);
          check_field("seg_hundreds", want.seg_hundreds, out_seg_hundreds);
          check_field("seg_tens",     want.seg_tens,     out_seg_tens);
          check_field("seg_ones",     want.seg_ones,     out_seg_ones);
          check_field("rain_level",   want.rain_level,   out_rain_level);
        end
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        case (cfg_index)
          REG_SAMPLE_INTERVAL: c_interval = cfg_data;
          REG_LIGHT_SWEEP:     c_light    = cfg_data;
          REG_MEDIUM_SWEEP:    c_medium   = cfg_data;
          REG_HEAVY_SWEEP:     c_heavy    = cfg_data;
          REG_BURST_PERIODS:   c_burst    = cfg_data[6:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        // The model always advances. A hand-written result takes its place in the queue.
        predicted = wiper_step(in_action, in_rain_sample);
        drive_words_q.push_back(row_fixed ? row_want : predicted);
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
  end

  // Watchdog: end the run if no channel moves for too long
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Output stall: short random bursts, or one long hold-off when asked.
  // The hold is counted here so that the sender keeps pushing into a full block.
  initial begin
    out_stall = 1'b0;
    holding   = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        holding   = 1'b1;
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall = 1'b0;
        holding   = 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Offer one word from a falling edge and hold it until it is taken. Return
  // on the next falling edge so that the next word can follow at once.
  task automatic send_word(input logic act, input logic [7:0] smp,
                           input logic fixed, input res_t want);
    row_fixed      = fixed;
    row_want       = want;
    in_action      = act;
    in_rain_sample = smp;
    in_valid       = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid for a random gap now and then. Do not gap during a long hold-off.
  task automatic pace_input();
    if (!quiet && !hold_req && !holding && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Drain: stop offering and wait until every expected word has come back.
  task automatic drain_results();
    in_valid = 1'b0;
    while (drive_words_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  // Pick a register value: zero, full scale, a small count or anything in range
  function automatic logic [7:0] pick_limit(input int unsigned top);
    case ($urandom_range(0, 3))
      0:       return 8'd0;
      1:       return top[7:0];
      2:       return 8'($urandom_range(1, 6));
      default: return 8'($urandom_range(0, top));
    endcase
  endfunction

  initial begin
    int unsigned ph;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_action      = ACT_TICK;
    in_rain_sample = '0;
    cfg_valid      = 1'b0;
    cfg_index      = REG_SAMPLE_INTERVAL;
    cfg_data       = '0;
    row_fixed      = 1'b0;
    row_want       = '0;
    quiet          = 1'b0;
    hold_req       = 1'b0;

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    // Latch on every tick so that the directed samples show at once
    write_reg(REG_SAMPLE_INTERVAL, 8'd0);
    foreach (DIR_ROWS[i]) begin
      pace_input();
      send_word(DIR_ROWS[i].act, DIR_ROWS[i].smp, DIR_ROWS[i].fixed, DIR_ROWS[i].want);
    end

    // Random phases. The first uses all zero limits: every tick latches, a tick
    // with rain reverses, and the drive stays off once the slot parks. The
    // second uses full scale everywhere. The rest are mixed, with mostly short
    // bursts so that the slot parks often.
    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      if (ph == 0) begin
        write_reg(REG_SAMPLE_INTERVAL, 8'd0);
        write_reg(REG_LIGHT_SWEEP,     8'd0);
        write_reg(REG_MEDIUM_SWEEP,    8'd0);
        write_reg(REG_HEAVY_SWEEP,     8'd0);
        write_reg(REG_BURST_PERIODS,   8'd0);
      end else if (ph == 1) begin
        write_reg(REG_SAMPLE_INTERVAL, 8'd255);
        write_reg(REG_LIGHT_SWEEP,     8'd255);
        write_reg(REG_MEDIUM_SWEEP,    8'd255);
        write_reg(REG_HEAVY_SWEEP,     8'd255);
        write_reg(REG_BURST_PERIODS,   8'd127);
      end else begin
        write_reg(REG_SAMPLE_INTERVAL, pick_limit(255));
        write_reg(REG_LIGHT_SWEEP,     pick_limit(255));
        write_reg(REG_MEDIUM_SWEEP,    pick_limit(255));
        write_reg(REG_HEAVY_SWEEP,     pick_limit(255));
        write_reg(REG_BURST_PERIODS,   pick_limit(127));
      end
      // Run the last phase without any stalls or gaps
      if (ph == PHASES - 1) quiet = 1'b1;
      // Hold the output off once while words keep coming, so that the block fills up
      if (ph == 2) hold_req = 1'b1;
      repeat (PHASE_WORDS) begin
        pace_input();
        send_word($urandom_range(0, 1) ? ACT_SLOT : ACT_TICK,
                  8'($urandom_range(0, 255)), 1'b0, '0);
      end
    end

    drain_results();
    repeat (4) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
